// ===== hw/rtl/timer_wheel_scheduler_macros.svh =====
// Assertion macros for the checker file of the timer wheel.
`ifndef TIMER_WHEEL_SCHEDULER_MACROS_SVH
`define TIMER_WHEEL_SCHEDULER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TWS_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("timer wheel assertion failed");

// Concurrent assertion on the block clock and reset.
`define TWS_ASSERT(lbl, prop) `TWS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/tws_pkg.sv =====
package tws_pkg;

  // Wheel geometry.
  localparam int WHEEL_SLOTS = 64;
  localparam int SLOT_DEPTH  = 8;

  localparam int SLOT_W = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOT_DEPTH + 1);
  localparam int ENT_W  = (WHEEL_SLOTS * SLOT_DEPTH > 1) ?
                          $clog2(WHEEL_SLOTS * SLOT_DEPTH) : 1;

  // Field widths.
  localparam int DLY_W     = 16;
  localparam int ID_W      = 8;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_W     = $clog2(DLY_W);
  localparam int PADDR_W   = 3;

  localparam logic [DLY_W-1:0] TICK_RESET = 16'd10;
  localparam logic             REG_TICK   = 1'b0;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_TICK     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_REJECTED  = 2'd1,
    KIND_FIRED     = 2'd2,
    KIND_NOTHING   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SLOT,
    S_FILL,
    S_SCHED,
    S_TICK_CHK,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_sched;
    logic load_tick;
    logic div_step;
    logic set_slot;
    logic fill_rd;
    logic sched_commit;
    logic nothing_out;
    logic emit_rd;
    logic emit_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic fill_zero;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

// ===== hw/rtl/tws_ctrl.sv =====
module tws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  tws_pkg::op_e  in_op_i,
  output logic          in_ready_o,
  input  tws_pkg::sts_t sts_i,
  output tws_pkg::cmd_t cmd_o
);

  tws_pkg::state_e state_q, state_d;
  logic            is_tick_q, is_tick_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tws_pkg::S_IDLE;
      is_tick_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_tick_q <= is_tick_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    is_tick_d  = is_tick_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tws_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == tws_pkg::OP_TICK) begin
            cmd_o.load_tick = 1'b1;
            is_tick_d       = 1'b1;
            state_d         = tws_pkg::S_FILL;
          end else begin
            cmd_o.load_sched = 1'b1;
            is_tick_d        = 1'b0;
            state_d          = tws_pkg::S_DIV;
          end
        end
      end
      tws_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = tws_pkg::S_SLOT;
        end
      end
      tws_pkg::S_SLOT: begin
        cmd_o.set_slot = 1'b1;
        state_d        = tws_pkg::S_FILL;
      end
      tws_pkg::S_FILL: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = is_tick_q ? tws_pkg::S_TICK_CHK : tws_pkg::S_SCHED;
      end
      tws_pkg::S_SCHED: begin
        if (sts_i.out_free) begin
          cmd_o.sched_commit = 1'b1;
          state_d            = tws_pkg::S_IDLE;
        end
      end
      tws_pkg::S_TICK_CHK: begin
        if (!sts_i.fill_zero) begin
          state_d = tws_pkg::S_EMIT_RD;
        end else if (sts_i.out_free) begin
          cmd_o.nothing_out = 1'b1;
          state_d           = tws_pkg::S_IDLE;
        end
      end
      tws_pkg::S_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = tws_pkg::S_EMIT_OUT;
      end
      tws_pkg::S_EMIT_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          state_d        = sts_i.emit_last ? tws_pkg::S_IDLE : tws_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_d = tws_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/tws_dp.sv =====
module tws_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tws_pkg::cmd_t                  cmd_i,
  output tws_pkg::sts_t                  sts_o,
  input  logic [tws_pkg::DLY_W-1:0]      tick_ms_i,
  input  logic [tws_pkg::DLY_W-1:0]      delay_i,
  input  logic [tws_pkg::ID_W-1:0]       id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_o_i,
  output tws_pkg::kind_e                 out_kind_o,
  output logic [tws_pkg::ID_W-1:0]       out_id_o,
  output logic [tws_pkg::IDX_OUT_W-1:0]  out_slot_o,
  output logic                           out_last_o
);

  localparam int SW = tws_pkg::SLOT_W;
  localparam int FW = tws_pkg::FILL_W;
  localparam int EW = tws_pkg::ENT_W;
  localparam int DW = tws_pkg::DLY_W;

  // Divider state.
  logic [DW-1:0]              dvd_q, dsr_q, rem_q;
  logic [tws_pkg::CNT_W-1:0]  cnt_q;
  logic [SW-1:0]              tm_q;
  logic                       qnz_q;
  logic [tws_pkg::ID_W-1:0]   id_q;

  // Wheel state.
  logic [SW-1:0]              cur_q, slot_q;
  logic [tws_pkg::WHEEL_SLOTS-1:0] vld_q;
  logic [FW-1:0]              idx_q;
  logic [FW-1:0]              fill_mem [tws_pkg::WHEEL_SLOTS];
  logic [FW-1:0]              fill_rd_q;
  logic [tws_pkg::ID_W-1:0]   ent_mem [tws_pkg::WHEEL_SLOTS * tws_pkg::SLOT_DEPTH];
  logic [tws_pkg::ID_W-1:0]   ent_rd_q;

  // Output register.
  logic                          out_valid_q;
  tws_pkg::kind_e                out_kind_q;
  logic [tws_pkg::ID_W-1:0]      out_id_q;
  logic [tws_pkg::IDX_OUT_W-1:0] out_slot_q;
  logic                          out_last_q;

  logic [DW:0]   trial, diff;
  logic          qbit;
  logic [SW:0]   tm2, tm2_sub;
  logic [SW:0]   addend, sum, sum_sub;
  logic [SW-1:0] slot_nxt;
  logic [FW-1:0] eff_fill;
  logic          fill_full;
  logic [EW-1:0] slot_base, wr_addr, rd_addr;
  logic          out_free, out_load;

  // One restoring divide step; the quotient bits are reduced modulo the slot count.
  assign trial   = {rem_q, dvd_q[DW-1]};
  assign diff    = trial - {1'b0, dsr_q};
  assign qbit    = (trial >= {1'b0, dsr_q});
  assign tm2     = {tm_q, qbit};
  assign tm2_sub = tm2 - (SW+1)'(tws_pkg::WHEEL_SLOTS);

  // Target slot: current position plus the tick count, wrapped once.
  assign addend   = (qnz_q && !cmd_i.load_tick) ? {1'b0, tm_q} : (SW+1)'(1);
  assign sum      = {1'b0, cur_q} + addend;
  assign sum_sub  = sum - (SW+1)'(tws_pkg::WHEEL_SLOTS);
  assign slot_nxt = (sum >= (SW+1)'(tws_pkg::WHEEL_SLOTS)) ? sum_sub[SW-1:0] : sum[SW-1:0];

  // A slot without its valid bit reads as empty.
  assign eff_fill  = vld_q[slot_q] ? fill_rd_q : '0;
  assign fill_full = (eff_fill >= FW'(tws_pkg::SLOT_DEPTH));
  assign slot_base = EW'(slot_q * tws_pkg::SLOT_DEPTH);
  assign wr_addr   = slot_base + EW'(eff_fill);
  assign rd_addr   = slot_base + EW'(idx_q);

  assign out_free = !out_valid_q || out_ready_o_i;
  assign out_load = cmd_i.sched_commit || cmd_i.nothing_out || cmd_i.emit_out;

  assign sts_o.div_done  = (cnt_q == tws_pkg::CNT_W'(DW - 1));
  assign sts_o.fill_zero = (eff_fill == '0);
  assign sts_o.out_free  = out_free;
  assign sts_o.emit_last = (FW'(idx_q + 1'b1) == eff_fill);

  // Divider registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      qnz_q <= 1'b0;
      tm_q  <= '0;
    end else if (cmd_i.load_sched) begin
      cnt_q <= '0;
      qnz_q <= 1'b0;
      tm_q  <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
      qnz_q <= qnz_q | qbit;
      tm_q  <= (tm2 >= (SW+1)'(tws_pkg::WHEEL_SLOTS)) ? tm2_sub[SW-1:0] : tm2[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sched) begin
      dvd_q <= delay_i;
      dsr_q <= (tick_ms_i == '0) ? DW'(1) : tick_ms_i;
      rem_q <= '0;
      id_q  <= id_i;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      rem_q <= qbit ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  // Wheel position, slot valid bits and emit index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      slot_q <= '0;
      vld_q  <= '0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.load_tick) begin
        cur_q  <= slot_nxt;
        slot_q <= slot_nxt;
        idx_q  <= '0;
      end
      if (cmd_i.set_slot) begin
        slot_q <= slot_nxt;
      end
      if (cmd_i.sched_commit && !fill_full) begin
        vld_q[slot_q] <= 1'b1;
      end
      if (cmd_i.emit_out) begin
        idx_q <= idx_q + 1'b1;
        if (sts_o.emit_last) begin
          vld_q[slot_q] <= 1'b0;
        end
      end
    end
  end

  // Fill count memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sched_commit && !fill_full) begin
      fill_mem[slot_q] <= eff_fill + 1'b1;
    end
    if (cmd_i.fill_rd) begin
      fill_rd_q <= fill_mem[slot_q];
    end
  end

  // Timer id memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sched_commit && !fill_full) begin
      ent_mem[wr_addr] <= id_q;
    end
    if (cmd_i.emit_rd) begin
      ent_rd_q <= ent_mem[rd_addr];
    end
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_o_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q <= tws_pkg::IDX_OUT_W'(slot_q);
      if (cmd_i.sched_commit) begin
        out_kind_q <= fill_full ? tws_pkg::KIND_REJECTED : tws_pkg::KIND_SCHEDULED;
        out_id_q   <= fill_full ? '0 : id_q;
        out_last_q <= 1'b1;
      end else if (cmd_i.nothing_out) begin
        out_kind_q <= tws_pkg::KIND_NOTHING;
        out_id_q   <= '0;
        out_last_q <= 1'b1;
      end else begin
        out_kind_q <= tws_pkg::KIND_FIRED;
        out_id_q   <= ent_rd_q;
        out_last_q <= sts_o.emit_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_id_o    = out_id_q;
  assign out_slot_o  = out_slot_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hw/rtl/timer_wheel_scheduler.sv =====
// Schedule word: the bit-serial delay divide, then slot compute, fill-count read and
// commit, which loads the result word.
// Tick word: advance, fill-count read and check, then a nothing-due word, or each fired
// id read and then loaded. One input word is in flight at a time; the next is taken
// the cycle after its last result is loaded, later while the result register stalls.
// Reset is asynchronous, active low: position 0, all slots empty by valid bit, 10 ms.
module timer_wheel_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tws_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // delay_ms[15:0], timer_id[23:16]
  input  logic [0:0]                    s_axis_tuser,  // opcode[0]
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // fired_id[7:0], slot_index[13:8]
  output logic [1:0]                    m_axis_tuser,  // kind[1:0]
  output logic                          m_axis_tlast
);

  logic [tws_pkg::DLY_W-1:0]     tick_q;
  tws_pkg::cmd_t                 cmd;
  tws_pkg::sts_t                 sts;
  tws_pkg::kind_e                out_kind;
  logic [tws_pkg::ID_W-1:0]      out_id;
  logic [tws_pkg::IDX_OUT_W-1:0] out_slot;
  logic                          reg_sel;

  // Tick interval register.
  assign reg_sel = (paddr[2] == tws_pkg::REG_TICK);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= tws_pkg::TICK_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      tick_q <= pwdata[tws_pkg::DLY_W-1:0];
    end
  end

  assign prdata = reg_sel ? {16'd0, tick_q} : 32'd0;

  tws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (tws_pkg::op_e'(s_axis_tuser[0])),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tws_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .tick_ms_i     (tick_q),
    .delay_i       (s_axis_tdata[15:0]),
    .id_i          (s_axis_tdata[23:16]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_o_i (m_axis_tready),
    .out_kind_o    (out_kind),
    .out_id_o      (out_id),
    .out_slot_o    (out_slot),
    .out_last_o    (m_axis_tlast)
  );

  // Result word packing.
  assign m_axis_tdata = {2'b00, out_slot, out_id};
  assign m_axis_tuser = out_kind;

endmodule

// ===== hw/rtl/tws_checker.sv =====
`include "timer_wheel_scheduler_macros.svh"

module tws_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [15:0]                 m_axis_tdata,
  input logic [1:0]                  m_axis_tuser,
  input logic                        m_axis_tlast
);

  // A stalled result word holds.
  `TWS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // Only fired ids may come in runs; every other result closes its input word.
  `TWS_ASSERT(a_single_last, m_axis_tvalid && m_axis_tuser != tws_pkg::KIND_FIRED |-> m_axis_tlast)

  // Rejected and nothing-due results carry a zero id.
  `TWS_ASSERT(a_zero_id, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)

  // The block works on one input word at a time.
  `TWS_ASSERT(a_one_word, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

endmodule

bind timer_wheel_scheduler tws_checker u_tws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/timer_wheel_scheduler_tb.sv =====
`timescale 1ns / 100ps

module timer_wheel_scheduler_tb;

  localparam int CLK_HALF_NS = 6;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int TAIL_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam logic [tws_pkg::PADDR_W-1:0] TICK_ADDR =
    tws_pkg::PADDR_W'(4 * int'(tws_pkg::REG_TICK));

  // One result word as the wheel reports it.
  typedef struct packed {
    tws_pkg::kind_e                kind;
    logic [tws_pkg::ID_W-1:0]      id;
    logic [tws_pkg::IDX_OUT_W-1:0] slot;
    logic                          last;
  } wheel_word_t;

  // Shadow wheel: tracks position, slot contents and the tick interval, and
  // keeps the result words that the block still owes.
  class wheel_scoreboard;
    logic [tws_pkg::DLY_W-1:0]  tick_ms;
    int unsigned                cur_pos;
    logic [tws_pkg::FILL_W-1:0] fill [tws_pkg::WHEEL_SLOTS];
    logic [tws_pkg::ID_W-1:0]   ids [tws_pkg::WHEEL_SLOTS][tws_pkg::SLOT_DEPTH];
    wheel_word_t                owed_words[$];
    int                         errors;
    int                         n_sched, n_reject, n_fired, n_nothing, n_items;

    function new();
      tick_ms = tws_pkg::TICK_RESET;
      cur_pos = 0;
      foreach (fill[s]) fill[s] = '0;
      errors = 0;
      n_sched = 0;
      n_reject = 0;
      n_fired = 0;
      n_nothing = 0;
      n_items = 0;
    endfunction

    function void set_tick(logic [tws_pkg::DLY_W-1:0] value);
      tick_ms = value;
    endfunction

    function int pending_count();
      return owed_words.size();
    endfunction

    function void owe(tws_pkg::kind_e kind, logic [tws_pkg::ID_W-1:0] id,
                      int unsigned slot, logic last);
      wheel_word_t w;
      w.kind = kind;
      w.id   = id;
      w.slot = slot[tws_pkg::IDX_OUT_W-1:0];
      w.last = last;
      owed_words.insert(owed_words.size(), w);
    endfunction

    // Work out the words caused by one accepted input word.
    function void take_item(tws_pkg::op_e op, logic [tws_pkg::DLY_W-1:0] dly,
                            logic [tws_pkg::ID_W-1:0] id);
      int unsigned divisor, ticks, slot, n;
      n_items++;
      if (op == tws_pkg::OP_SCHEDULE) begin
        // A zero interval divides as one; a zero quotient still waits a tick.
        divisor = (tick_ms == '0) ? 1 : tick_ms;
        ticks = dly / divisor;
        if (ticks == 0) ticks = 1;
        slot = (cur_pos + ticks) % tws_pkg::WHEEL_SLOTS;
        if (fill[slot] >= tws_pkg::SLOT_DEPTH) begin
          owe(tws_pkg::KIND_REJECTED, '0, slot, 1'b1);
        end else begin
          ids[slot][fill[slot]] = id;
          fill[slot] = fill[slot] + 1'b1;
          owe(tws_pkg::KIND_SCHEDULED, id, slot, 1'b1);
        end
      end else begin
        // Advance first, then drain the new current slot in insertion order.
        cur_pos = (cur_pos + 1) % tws_pkg::WHEEL_SLOTS;
        n = fill[cur_pos];
        if (n == 0) begin
          owe(tws_pkg::KIND_NOTHING, '0, cur_pos, 1'b1);
        end else begin
          for (int unsigned i = 0; i < n; i++)
            owe(tws_pkg::KIND_FIRED, ids[cur_pos][i], cur_pos, (i + 1 == n));
          fill[cur_pos] = '0;
        end
      end
    endfunction

    // Compare one accepted result word with the oldest owed word.
    function void check_word(tws_pkg::kind_e kind, logic [tws_pkg::ID_W-1:0] id,
                             logic [tws_pkg::IDX_OUT_W-1:0] slot, logic last);
      wheel_word_t exp_w;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d id=%0h slot=%0d last=%0b",
                 $time, kind, id, slot, last);
        errors++;
        return;
      end
      exp_w = owed_words.pop_front();
      if (kind !== exp_w.kind) begin
        $display("%0t: kind mismatch: expected %0d, actual %0d", $time, exp_w.kind, kind);
        errors++;
      end
      if (id !== exp_w.id) begin
        $display("%0t: fired_id mismatch: expected %0h, actual %0h", $time, exp_w.id, id);
        errors++;
      end
      if (slot !== exp_w.slot) begin
        $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                 $time, exp_w.slot, slot);
        errors++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, exp_w.last, last);
        errors++;
      end
      case (exp_w.kind)
        tws_pkg::KIND_SCHEDULED: n_sched++;
        tws_pkg::KIND_REJECTED:  n_reject++;
        tws_pkg::KIND_FIRED:     n_fired++;
        default:                 n_nothing++;
      endcase
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tws_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // delay_ms[15:0], timer_id[23:16]
  logic [0:0]  s_axis_tuser = '0;  // opcode[0]

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;       // fired_id[7:0], slot_index[13:8]
  logic [1:0]  m_axis_tuser;       // kind[1:0]
  logic        m_axis_tlast;

  wheel_scoreboard sb;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  int sink_hold = 0;
  int n_settings = 0;

  timer_wheel_scheduler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin : clock_gen
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: a long hold when asked for, random stall bursts otherwise.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (sink_idle_en && rst_ni && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(tws_pkg::kind_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[13:8],
                    m_axis_tlast);
  end

  // Offer one input word and wait until it is taken. Valid stays high when
  // the next word follows at once.
  task automatic push_item(tws_pkg::op_e op, logic [tws_pkg::DLY_W-1:0] dly,
                           logic [tws_pkg::ID_W-1:0] id);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {id, dly};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(op, dly, id);
  endtask

  task automatic wait_drained();
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [tws_pkg::PADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read the tick interval back and compare it with the shadow copy.
  task automatic check_tick_reg();
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= TICK_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {16'd0, sb.tick_ms}) begin
      $display("%0t: tick_interval_ms readback: expected %0h, actual %0h",
               $time, {16'd0, sb.tick_ms}, rd);
      sb.errors++;
    end
  endtask

  // New tick interval, written only once the wheel has gone quiet.
  task automatic retune(logic [tws_pkg::DLY_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    apb_write(TICK_ADDR, {16'd0, value});
    sb.set_tick(value);
    n_settings++;
    check_tick_reg();
  endtask

  // Random traffic: mostly delays that land a few ticks ahead so slots fill
  // up and overflow, some full-range delays, some that wrap past a revolution.
  task automatic run_phase(int n_items, logic [tws_pkg::DLY_W-1:0] value, bit quiet,
                           int hold_at, int drain_at);
    int unsigned eff, dly, pick;
    retune(value);
    eff = (value == '0) ? 1 : value;
    for (int i = 0; i < n_items; i++) begin
      src_idle_en  = !quiet && ((i / 12) % 3 != 2);
      sink_idle_en = src_idle_en;
      if (i == hold_at) sink_hold = LONG_HOLD_CYCLES;
      if (i == drain_at) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      if ($urandom_range(0, 99) < 35) begin
        push_item(tws_pkg::OP_TICK, tws_pkg::DLY_W'($urandom), tws_pkg::ID_W'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          dly = $urandom_range(0, eff * 12);
        else if (pick < 8)
          dly = $urandom_range(0, 65535);
        else
          dly = eff * tws_pkg::WHEEL_SLOTS * $urandom_range(1, 3) +
                $urandom_range(0, eff * 2);
        if (dly > 65535) dly = 65535;
        push_item(tws_pkg::OP_SCHEDULE, tws_pkg::DLY_W'(dly), tws_pkg::ID_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_tick_reg();

    // Directed: default interval, fill one slot past its depth, drain it,
    // an empty tick, and delays at and just under one revolution.
    push_item(tws_pkg::OP_SCHEDULE, 16'd0, 8'h00);
    push_item(tws_pkg::OP_SCHEDULE, 16'hFFFF, 8'hFF);
    push_item(tws_pkg::OP_SCHEDULE, 16'd5, 8'hA5);
    push_item(tws_pkg::OP_SCHEDULE, 16'd9, 8'h5A);
    push_item(tws_pkg::OP_SCHEDULE, 16'd10, 8'h01);
    push_item(tws_pkg::OP_SCHEDULE, 16'd19, 8'h80);
    push_item(tws_pkg::OP_SCHEDULE, 16'd3, 8'h7F);
    push_item(tws_pkg::OP_SCHEDULE, 16'd12, 8'hFE);
    push_item(tws_pkg::OP_SCHEDULE, 16'd7, 8'h33);
    push_item(tws_pkg::OP_SCHEDULE, 16'd15, 8'h3C);
    push_item(tws_pkg::OP_TICK, 16'hFFFF, 8'hFF);
    push_item(tws_pkg::OP_TICK, 16'h0000, 8'h00);
    push_item(tws_pkg::OP_SCHEDULE, 16'd640, 8'hC3);
    push_item(tws_pkg::OP_SCHEDULE, 16'd630, 8'h96);

    // A zero interval divides as one.
    retune(16'd0);
    push_item(tws_pkg::OP_SCHEDULE, 16'd1, 8'h81);
    push_item(tws_pkg::OP_SCHEDULE, 16'hFFFF, 8'h18);

    // Largest interval: every delay rounds to one tick.
    retune(16'hFFFF);
    push_item(tws_pkg::OP_SCHEDULE, 16'hFFFF, 8'h42);
    push_item(tws_pkg::OP_SCHEDULE, 16'hFFFE, 8'h24);

    retune(16'd1);
    push_item(tws_pkg::OP_SCHEDULE, 16'd2, 8'h99);
    push_item(tws_pkg::OP_TICK, 16'h5555, 8'hAA);
    push_item(tws_pkg::OP_TICK, 16'hAAAA, 8'h55);
    push_item(tws_pkg::OP_TICK, 16'd0, 8'h00);

    // Random phases over several intervals; the last runs without idling.
    run_phase(40, 16'd3, 1'b0, 10, -1);
    run_phase(40, 16'hFFFF, 1'b0, -1, 20);
    run_phase(40, 16'd1, 1'b0, -1, -1);
    run_phase(40, 16'd0, 1'b0, -1, -1);
    run_phase(40, 16'($urandom_range(2, 400)), 1'b0, -1, -1);
    run_phase(40, tws_pkg::TICK_RESET, 1'b1, -1, -1);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d input words over %0d tick interval settings.", sb.n_items, n_settings);
    $display("Words checked: %0d scheduled, %0d rejected, %0d fired, %0d nothing due.",
             sb.n_sched, sb.n_reject, sb.n_fired, sb.n_nothing);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
